### hw/rtl/bsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser package
// Shared types and constants for the BMP byte-stream parser and its checker.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_PIXEL  = 6'b000100,
    PH_PAD    = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_e;

  // Kind of a result transaction, carried on the master tuser.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes reported with an error result.
  typedef enum logic [2:0] {
    ERR_SIGNATURE   = 3'd0,
    ERR_INFO_SIZE   = 3'd1,
    ERR_PLANES      = 3'd2,
    ERR_BIT_COUNT   = 3'd3,
    ERR_COMPRESSION = 3'd4,
    ERR_TOO_LARGE   = 3'd5
  } err_e;

  // Byte positions at which a little-endian header field is complete.
  localparam logic [5:0] POS_SIGNATURE   = 6'd1;
  localparam logic [5:0] POS_OFFSET      = 6'd13;
  localparam logic [5:0] POS_INFO_SIZE   = 6'd17;
  localparam logic [5:0] POS_WIDTH       = 6'd21;
  localparam logic [5:0] POS_HEIGHT      = 6'd25;
  localparam logic [5:0] POS_PLANES      = 6'd27;
  localparam logic [5:0] POS_BIT_COUNT   = 6'd29;
  localparam logic [5:0] POS_COMPRESSION = 6'd33;
  localparam logic [5:0] POS_HEADER_END  = 6'd53;

  // Header field values.
  localparam logic [7:0]  SIG_FIRST   = 8'h42;  // 'B'
  localparam logic [7:0]  SIG_SECOND  = 8'h4D;  // 'M'
  localparam logic [31:0] INFO_SIZE   = 32'd40;
  localparam logic [15:0] ONE_PLANE   = 16'd1;
  localparam logic [15:0] BPP_24      = 16'd24;
  localparam logic [15:0] BPP_16      = 16'd16;
  localparam logic [31:0] PIXEL_START = 32'd54;

  // Result field widths and the packed master tdata width.
  localparam int unsigned ERR_CODE_W = 3;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned M_TDATA_W  = 80;

endpackage

### hw/rtl/bmp_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser
// Decodes a BMP file fed one byte per transaction into header, pixel and error results.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one file byte per transaction in tdata; tuser high
//   marks the first byte of a new file and restarts the parser on that byte.
//   The master channel gives at most one result per input byte: tuser holds the
//   result kind (pixel, header accepted, error) and tlast marks the last pixel.
//   The header is checked as it streams in; a failed check gives one error
//   result and the rest of the file is ignored until the next first byte.
//   A good header gives one result on byte 53, then one result per pixel once
//   its last byte arrives, with row padding dropped.
// Output timing and throughput:
//   A result shows on the master side in the cycle after the byte that completes
//   it is accepted. All decoding sits between the slave handshake and a single
//   output register; one byte is taken every cycle unless the output is stalled.
// Reset and stall:
//   Reset puts the parser at byte 0 of the header with the output empty.
//   While a result waits on a stalled master side, the slave side holds off; it
//   is ready whenever the output register is empty or the master side is ready.
// ----------------------------------------------------------------------------
module bmp_stream_parser #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave side.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] file_byte
  input  logic                           s_axis_tuser,   // [0] first_byte
  // Master side.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] error_code, [15:3] image_width, [28:16] image_height,
  // [29] is_24_bit, [41:30] pixel_x, [53:42] pixel_y, [61:54] byte_first,
  // [69:62] byte_second, [77:70] byte_third, [79:78] zero
  output logic [bsp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,   // [1:0] result_kind
  output logic                           m_axis_tlast    // last_pixel
);

  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COORD_W_L = bsp_pkg::COORD_W;

  // Parser state.
  bsp_pkg::phase_e phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     shift_q, shift_d;
  logic [WW-1:0]   width_q, width_d;
  logic [HW-1:0]   height_q, height_d;
  logic [31:0]     offset_q, offset_d;
  logic            deep_q, deep_d;
  logic [WW-1:0]   col_q, col_d;
  logic [HW-1:0]   row_q, row_d;
  logic [1:0]      pidx_q, pidx_d;
  logic [15:0]     held_q, held_d;
  logic [1:0]      pad_q, pad_d;

  // Output register.
  logic                          out_valid_q;
  logic [bsp_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]                    out_kind_q;
  logic                          out_last_q;

  logic            s_acc;
  logic [7:0]      in_byte;
  logic            restart;

  // State seen by this byte: a first byte starts from the reset state.
  bsp_pkg::phase_e cur_phase;
  logic [31:0]     cur_pos;
  logic [WW-1:0]   cur_col;
  logic [HW-1:0]   cur_row;
  logic [1:0]      cur_pidx;

  // Result of this byte.
  logic                 res_valid;
  bsp_pkg::kind_e       res_kind;
  bsp_pkg::err_e        res_err;
  logic                 res_dims;
  logic [COORD_W_L-1:0] res_x, res_y;
  logic [7:0]           res_b1, res_b2, res_b3;
  logic                 res_last;

  // Pixel bookkeeping.
  logic [WW:0]     col_next;
  logic [HW:0]     row_next;
  logic            pix_emit;
  logic            pix_last;
  logic [HW-1:0]   y_down;
  logic [1:0]      w_lo;
  logic [1:0]      pad_bytes;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_byte       = s_axis_tdata;
  assign restart       = s_axis_tuser;

  assign cur_phase = restart ? bsp_pkg::PH_HEADER : phase_q;
  assign cur_pos   = restart ? 32'd0 : pos_q;
  assign cur_col   = restart ? '0 : col_q;
  assign cur_row   = restart ? '0 : row_q;
  assign cur_pidx  = restart ? 2'd0 : pidx_q;

  // Pixel position and padding helpers.
  assign col_next  = (WW + 1)'(cur_col) + (WW + 1)'(1);
  assign row_next  = (HW + 1)'(cur_row) + (HW + 1)'(1);
  assign pix_emit  = deep_q ? (cur_pidx == 2'd2) : (cur_pidx == 2'd1);
  assign pix_last  = (col_next == (WW + 1)'(width_q)) && (row_next == (HW + 1)'(height_q));
  assign y_down    = height_q - HW'(1) - cur_row;
  assign w_lo      = 2'(width_q);
  // Row bytes mod 4 is w*3 or w*2; the padding brings it up to a multiple of 4.
  assign pad_bytes = deep_q ? w_lo : {w_lo[0], 1'b0};

  // Next state and result of the accepted byte.
  always_comb begin
    phase_d   = cur_phase;
    pos_d     = cur_pos;
    shift_d   = shift_q;
    width_d   = width_q;
    height_d  = height_q;
    offset_d  = offset_q;
    deep_d    = deep_q;
    col_d     = cur_col;
    row_d     = cur_row;
    pidx_d    = cur_pidx;
    held_d    = held_q;
    pad_d     = pad_q;
    res_valid = 1'b0;
    res_kind  = bsp_pkg::KIND_PIXEL;
    res_err   = bsp_pkg::ERR_SIGNATURE;
    res_dims  = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_b1    = 8'd0;
    res_b2    = 8'd0;
    res_b3    = 8'd0;
    res_last  = 1'b0;

    case (cur_phase)
      bsp_pkg::PH_HEADER: begin
        shift_d = {in_byte, shift_q[31:8]};
        pos_d   = cur_pos + 32'd1;
        case (cur_pos[5:0])
          bsp_pkg::POS_SIGNATURE: begin
            if (shift_d[23:16] != bsp_pkg::SIG_FIRST || shift_d[31:24] != bsp_pkg::SIG_SECOND) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_SIGNATURE;
              phase_d   = bsp_pkg::PH_ERROR;
            end
          end
          bsp_pkg::POS_OFFSET: begin
            offset_d = shift_d;
          end
          bsp_pkg::POS_INFO_SIZE: begin
            if (shift_d != bsp_pkg::INFO_SIZE) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_INFO_SIZE;
              phase_d   = bsp_pkg::PH_ERROR;
            end
          end
          bsp_pkg::POS_WIDTH: begin
            if (shift_d > 32'(MAX_WIDTH)) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_TOO_LARGE;
              phase_d   = bsp_pkg::PH_ERROR;
            end else begin
              width_d = WW'(shift_d);
            end
          end
          bsp_pkg::POS_HEIGHT: begin
            if (shift_d > 32'(MAX_HEIGHT)) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_TOO_LARGE;
              phase_d   = bsp_pkg::PH_ERROR;
            end else begin
              height_d = HW'(shift_d);
            end
          end
          bsp_pkg::POS_PLANES: begin
            if (shift_d[31:16] != bsp_pkg::ONE_PLANE) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_PLANES;
              phase_d   = bsp_pkg::PH_ERROR;
            end
          end
          bsp_pkg::POS_BIT_COUNT: begin
            if (shift_d[31:16] == bsp_pkg::BPP_24) begin
              deep_d = 1'b1;
            end else if (shift_d[31:16] == bsp_pkg::BPP_16) begin
              deep_d = 1'b0;
            end else begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_BIT_COUNT;
              phase_d   = bsp_pkg::PH_ERROR;
            end
          end
          bsp_pkg::POS_COMPRESSION: begin
            if (shift_d != 32'd0) begin
              res_valid = 1'b1;
              res_kind  = bsp_pkg::KIND_ERROR;
              res_err   = bsp_pkg::ERR_COMPRESSION;
              phase_d   = bsp_pkg::PH_ERROR;
            end
          end
          bsp_pkg::POS_HEADER_END: begin
            res_valid = 1'b1;
            res_kind  = bsp_pkg::KIND_HEADER;
            res_dims  = 1'b1;
            if (width_q == '0 || height_q == '0) begin
              phase_d = bsp_pkg::PH_DONE;
            end else if (offset_q > bsp_pkg::PIXEL_START) begin
              phase_d = bsp_pkg::PH_SKIP;
            end else begin
              phase_d = bsp_pkg::PH_PIXEL;
            end
          end
          default: begin
          end
        endcase
      end

      // Gap between the headers and the pixel array.
      bsp_pkg::PH_SKIP: begin
        pos_d = cur_pos + 32'd1;
        if (pos_d >= offset_q) begin
          phase_d = bsp_pkg::PH_PIXEL;
        end
      end

      // Collect pixel bytes and emit on the last one.
      bsp_pkg::PH_PIXEL: begin
        if (!pix_emit) begin
          if (cur_pidx[0]) begin
            held_d[15:8] = in_byte;
          end else begin
            held_d[7:0] = in_byte;
          end
          pidx_d = cur_pidx + 2'd1;
        end else begin
          res_valid = 1'b1;
          res_kind  = bsp_pkg::KIND_PIXEL;
          res_dims  = 1'b1;
          res_x     = COORD_W_L'(cur_col);
          res_y     = deep_q ? COORD_W_L'(cur_row) : COORD_W_L'(y_down);
          res_b1    = held_q[7:0];
          res_b2    = deep_q ? held_q[15:8] : in_byte;
          res_b3    = deep_q ? in_byte : 8'd0;
          res_last  = pix_last;
          pidx_d    = 2'd0;
          if (pix_last) begin
            phase_d = bsp_pkg::PH_DONE;
          end else if (col_next == (WW + 1)'(width_q)) begin
            col_d = '0;
            row_d = HW'(row_next);
            if (pad_bytes != 2'd0) begin
              pad_d   = pad_bytes;
              phase_d = bsp_pkg::PH_PAD;
            end
          end else begin
            col_d = WW'(col_next);
          end
        end
      end

      // Drop the row padding.
      bsp_pkg::PH_PAD: begin
        pad_d = pad_q - 2'd1;
        if (pad_d == 2'd0) begin
          phase_d = bsp_pkg::PH_PIXEL;
        end
      end

      default: begin
      end
    endcase
  end

  // Pack the result transaction.
  always_comb begin
    out_data_d = {2'b00, res_b3, res_b2, res_b1, res_y, res_x,
                  res_dims & deep_q,
                  res_dims ? bsp_pkg::DIM_W'(height_q) : bsp_pkg::DIM_W'(0),
                  res_dims ? bsp_pkg::DIM_W'(width_q) : bsp_pkg::DIM_W'(0),
                  (res_kind == bsp_pkg::KIND_ERROR) ? res_err : bsp_pkg::ERR_SIGNATURE};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bsp_pkg::PH_HEADER;
      pos_q   <= 32'd0;
      col_q   <= '0;
      row_q   <= '0;
      pidx_q  <= 2'd0;
      pad_q   <= 2'd0;
    end else if (s_acc) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pidx_q  <= pidx_d;
      pad_q   <= pad_d;
    end
  end

  // Header fields and held pixel bytes.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      shift_q  <= shift_d;
      width_q  <= width_d;
      height_q <= height_d;
      offset_q <= offset_d;
      deep_q   <= deep_d;
      held_q   <= held_d;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (s_acc && res_valid) begin
      out_data_q <= out_data_d;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/bsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser checker
// Port-level assertions on the parser's handshakes and results, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bsp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // A stalled result transaction keeps its payload.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // An empty output register never holds off the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // Only a pixel result can close the image.
  a_last_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == bsp_pkg::KIND_PIXEL)
    else $error("last flag on a non-pixel result");

  // Error codes appear on error results alone; the kind stays in range.
  a_code_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != bsp_pkg::KIND_ERROR |->
      m_axis_tdata[bsp_pkg::ERR_CODE_W-1:0] == bsp_pkg::ERR_SIGNATURE &&
      (m_axis_tuser == bsp_pkg::KIND_PIXEL || m_axis_tuser == bsp_pkg::KIND_HEADER))
    else $error("bad result kind or stray error code");

  // Results follow accepted bytes: a new one never appears without an input transaction.
  a_result_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an input transaction");

endmodule

bind bmp_stream_parser bsp_checker u_bsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### test/bmp_stream_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser result checker
// Follows every byte the parser accepts, works out the result that byte should
// produce, and compares each result the parser hands out against the oldest
// outstanding prediction. Mismatches and the number of outstanding results are
// reported to the testbench top.
// ----------------------------------------------------------------------------
module bmp_stream_parser_checker
  import bsp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Slave side of the parser, observed only.
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,    // [7:0] file_byte
  input  logic                 s_axis_tuser,    // [0] first_byte
  // Master side of the parser, observed only.
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] error_code, [15:3] image_width, [28:16] image_height,
  // [29] is_24_bit, [41:30] pixel_x, [53:42] pixel_y, [61:54] byte_first,
  // [69:62] byte_second, [77:70] byte_third, [79:78] zero
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic [1:0]           m_axis_tuser,    // [1:0] result_kind
  input  logic                 m_axis_tlast,    // last_pixel
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_count_o
);

  // One decoded parser result.
  typedef struct packed {
    kind_e             kind;
    err_e              code;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  img_h;
    logic              deep;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic              last;
  } parse_result_t;

  // Predicted parser state.
  phase_e      ph;
  int unsigned pos;
  logic [31:0] shreg;
  int unsigned wid;
  int unsigned hgt;
  logic [31:0] off;
  logic        deep;
  int unsigned col;
  int unsigned row;
  int unsigned pidx;
  logic [15:0] held;
  int unsigned pad_left;

  parse_result_t results_q[$];
  int unsigned   fails;

  function automatic void clear_parser();
    ph       = PH_HEADER;
    pos      = 0;
    shreg    = '0;
    wid      = 0;
    hgt      = 0;
    off      = '0;
    deep     = 1'b0;
    col      = 0;
    row      = 0;
    pidx     = 0;
    held     = '0;
    pad_left = 0;
  endfunction

  // Header bytes: shift in, check each field on its last byte.
  function automatic void header_byte(input logic [7:0] b, output bit hit,
                                      output parse_result_t r);
    int unsigned p;
    bit          bad;
    err_e        ec;
    p     = pos;
    pos   = pos + 1;
    shreg = {b, shreg[31:8]};
    bad   = 1'b0;
    ec    = ERR_SIGNATURE;
    hit   = 1'b0;
    r     = '0;
    case (p)
      POS_SIGNATURE: begin
        if (shreg[23:16] != SIG_FIRST || shreg[31:24] != SIG_SECOND) begin
          bad = 1'b1;
          ec  = ERR_SIGNATURE;
        end
      end
      POS_OFFSET: off = shreg;
      POS_INFO_SIZE: begin
        if (shreg != INFO_SIZE) begin
          bad = 1'b1;
          ec  = ERR_INFO_SIZE;
        end
      end
      POS_WIDTH: begin
        if (shreg > MAX_WIDTH) begin
          bad = 1'b1;
          ec  = ERR_TOO_LARGE;
        end else begin
          wid = shreg;
        end
      end
      POS_HEIGHT: begin
        if (shreg > MAX_HEIGHT) begin
          bad = 1'b1;
          ec  = ERR_TOO_LARGE;
        end else begin
          hgt = shreg;
        end
      end
      POS_PLANES: begin
        if (shreg[31:16] != ONE_PLANE) begin
          bad = 1'b1;
          ec  = ERR_PLANES;
        end
      end
      POS_BIT_COUNT: begin
        if (shreg[31:16] == BPP_24) begin
          deep = 1'b1;
        end else if (shreg[31:16] == BPP_16) begin
          deep = 1'b0;
        end else begin
          bad = 1'b1;
          ec  = ERR_BIT_COUNT;
        end
      end
      POS_COMPRESSION: begin
        if (shreg != 32'd0) begin
          bad = 1'b1;
          ec  = ERR_COMPRESSION;
        end
      end
      POS_HEADER_END: begin
        hit     = 1'b1;
        r.kind  = KIND_HEADER;
        r.img_w = DIM_W'(wid);
        r.img_h = DIM_W'(hgt);
        r.deep  = deep;
        if (wid == 0 || hgt == 0) ph = PH_DONE;
        else if (off > PIXEL_START) ph = PH_SKIP;
        else ph = PH_PIXEL;
      end
      default: ;
    endcase
    if (bad) begin
      hit    = 1'b1;
      r.kind = KIND_ERROR;
      r.code = ec;
      ph     = PH_ERROR;
    end
  endfunction

  // Pixel bytes: collect 2 or 3 bytes, then give one pixel result.
  function automatic void pixel_byte(input logic [7:0] b, output bit hit,
                                     output parse_result_t r);
    int unsigned need;
    int unsigned yv;
    int unsigned pad;
    need = deep ? 3 : 2;
    hit  = 1'b0;
    r    = '0;
    if (pidx + 1 < need) begin
      held = held | (16'(b) << (8 * (pidx & 1)));
      pidx = pidx + 1;
    end else begin
      yv      = deep ? row : hgt - 1 - row;
      hit     = 1'b1;
      r.kind  = KIND_PIXEL;
      r.img_w = DIM_W'(wid);
      r.img_h = DIM_W'(hgt);
      r.deep  = deep;
      r.px    = COORD_W'(col);
      r.py    = COORD_W'(yv);
      r.b0    = held[7:0];
      r.b1    = deep ? held[15:8] : b;
      r.b2    = deep ? b : 8'd0;
      r.last  = (col + 1 == wid) && (row + 1 == hgt);
      pidx    = 0;
      held    = '0;
      if (r.last) begin
        ph = PH_DONE;
      end else begin
        col = col + 1;
        if (col == wid) begin
          col = 0;
          row = row + 1;
          pad = (4 - ((wid * need) & 3)) & 3;
          if (pad != 0) begin
            pad_left = pad;
            ph       = PH_PAD;
          end
        end
      end
    end
  endfunction

  // Advance the predicted parser by one accepted byte.
  function automatic void step_parser(input logic [7:0] b, input logic first,
                                      output bit hit, output parse_result_t r);
    hit = 1'b0;
    r   = '0;
    if (first) clear_parser();
    case (ph)
      PH_HEADER: header_byte(b, hit, r);
      PH_SKIP: begin
        pos = pos + 1;
        if (pos >= off) ph = PH_PIXEL;
      end
      PH_PIXEL: pixel_byte(b, hit, r);
      PH_PAD: begin
        pad_left = (pad_left - 1) & 3;
        if (pad_left == 0) ph = PH_PIXEL;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fails = fails + 1;
    end
  endfunction

  // Compare results on the master side, then predict from the slave side.
  always @(posedge clk_i or negedge rst_ni) begin
    bit            hit;
    parse_result_t want;
    parse_result_t seen;
    if (!rst_ni) begin
      clear_parser();
      results_q.delete();
      fails = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind  = kind_e'(m_axis_tuser);
        seen.code  = err_e'(m_axis_tdata[2:0]);
        seen.img_w = m_axis_tdata[15:3];
        seen.img_h = m_axis_tdata[28:16];
        seen.deep  = m_axis_tdata[29];
        seen.px    = m_axis_tdata[41:30];
        seen.py    = m_axis_tdata[53:42];
        seen.b0    = m_axis_tdata[61:54];
        seen.b1    = m_axis_tdata[69:62];
        seen.b2    = m_axis_tdata[77:70];
        seen.last  = m_axis_tlast;
        if (results_q.size() == 0) begin
          $error("unexpected result transaction of kind %0d", m_axis_tuser);
          fails = fails + 1;
        end else begin
          want = results_q.pop_front();
          check_field("result_kind", want.kind, seen.kind);
          check_field("error_code", want.code, seen.code);
          check_field("image_width", want.img_w, seen.img_w);
          check_field("image_height", want.img_h, seen.img_h);
          check_field("is_24_bit", want.deep, seen.deep);
          check_field("pixel_x", want.px, seen.px);
          check_field("pixel_y", want.py, seen.py);
          check_field("byte_first", want.b0, seen.b0);
          check_field("byte_second", want.b1, seen.b1);
          check_field("byte_third", want.b2, seen.b2);
          check_field("last_pixel", want.last, seen.last);
          check_field("zero padding of tdata", 0, m_axis_tdata[79:78]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_parser(s_axis_tdata, s_axis_tuser, hit, want);
        if (hit) results_q.push_back(want);
      end
      mismatch_count_o <= fails;
      pending_count_o  <= results_q.size();
    end
  end

endmodule

### test/bmp_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream parser testbench
// Feeds the parser whole BMP files byte by byte: a directed set covering every
// header check, the dimension limits, small and large pixel offsets, empty and
// truncated images, then randomly built files that are mostly well formed.
// Both channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module bmp_stream_parser_tb;
  import bsp_pkg::*;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 280;
  localparam int unsigned DRAIN_LIMIT  = 2000;

  // First byte of each little-endian header field.
  localparam int unsigned AT_OFFSET      = POS_OFFSET - 3;
  localparam int unsigned AT_INFO_SIZE   = POS_INFO_SIZE - 3;
  localparam int unsigned AT_WIDTH       = POS_WIDTH - 3;
  localparam int unsigned AT_HEIGHT      = POS_HEIGHT - 3;
  localparam int unsigned AT_PLANES      = POS_PLANES - 1;
  localparam int unsigned AT_BIT_COUNT   = POS_BIT_COUNT - 1;
  localparam int unsigned AT_COMPRESSION = POS_COMPRESSION - 3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'd0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int unsigned mismatches;
  int unsigned waiting;
  bit          calm         = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned ready_roll;
  int unsigned cycles       = 0;
  int unsigned random_bytes = 0;
  logic [7:0]  file_q[$];

  bmp_stream_parser #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  bmp_stream_parser_checker #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) parse_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .mismatch_count_o(mismatches),
    .pending_count_o (waiting)
  );

  // Clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure: mostly short stalls, a few long ones.
  always @(posedge clk_i) begin
    ready_roll = $urandom_range(0, 99);
    if (calm || !rst_ni) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (ready_roll < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left    <= (ready_roll < 96) ? $urandom_range(0, 2) : $urandom_range(6, 30);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one byte and hold it until the parser takes it.
  task automatic send_byte(input logic [7:0] value, input logic restart);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_file(input bit restart);
    for (int unsigned i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], restart && (i == 0));
    end
  endtask

  function automatic void put_le(input int unsigned at, input logic [31:0] value,
                                 input int unsigned nbytes);
    for (int unsigned k = 0; k < nbytes; k++) file_q[at + k] = value[8*k +: 8];
  endfunction

  function automatic void add_junk(input int unsigned nbytes);
    repeat (nbytes) file_q.push_back(8'($urandom));
  endfunction

  // A valid 54-byte header; fields that the parser ignores are random.
  function automatic void start_header(input logic [31:0] w, input logic [31:0] h,
                                       input logic [31:0] offset, input logic [15:0] bpp);
    file_q.delete();
    add_junk(PIXEL_START);
    file_q[0] = SIG_FIRST;
    file_q[1] = SIG_SECOND;
    put_le(AT_OFFSET, offset, 4);
    put_le(AT_INFO_SIZE, INFO_SIZE, 4);
    put_le(AT_WIDTH, w, 4);
    put_le(AT_HEIGHT, h, 4);
    put_le(AT_PLANES, 32'(ONE_PLANE), 2);
    put_le(AT_BIT_COUNT, 32'(bpp), 2);
    put_le(AT_COMPRESSION, 32'd0, 4);
  endfunction

  // Gap up to the pixel offset, then up to a given number of padded rows.
  function automatic void add_pixels(input int unsigned w, input int unsigned h,
                                     input logic [15:0] bpp, input logic [31:0] offset,
                                     input int unsigned rows);
    int unsigned px_bytes;
    int unsigned pad;
    int unsigned roll;
    px_bytes = (bpp == BPP_24) ? 3 : 2;
    pad      = (4 - (w * px_bytes) % 4) % 4;
    if (offset > PIXEL_START) add_junk(offset - PIXEL_START);
    for (int unsigned r = 0; r < rows && r < h; r++) begin
      repeat (w * px_bytes) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) file_q.push_back(8'h00);
        else if (roll == 1) file_q.push_back(8'hFF);
        else file_q.push_back(8'($urandom));
      end
      add_junk(pad);
    end
  endfunction

  // A header with one field set to a value that must be rejected.
  task automatic send_bad_header(input int unsigned at, input logic [31:0] value,
                                 input int unsigned nbytes);
    start_header(2, 2, PIXEL_START, BPP_24);
    put_le(at, value, nbytes);
    add_junk(3);
    send_file(1'b1);
  endtask

  task automatic run_directed();
    // Bad first signature byte, straight after reset without a restart flag.
    file_q.delete();
    file_q.push_back(8'h43);
    file_q.push_back(SIG_SECOND);
    add_junk(2);
    send_file(1'b0);
    // Bad second signature byte.
    file_q.delete();
    file_q.push_back(SIG_FIRST);
    file_q.push_back(8'h4E);
    add_junk(2);
    send_file(1'b1);
    // Each remaining header check.
    send_bad_header(AT_INFO_SIZE, 32'd12, 4);
    send_bad_header(AT_WIDTH, MAX_DIM + 1, 4);
    send_bad_header(AT_HEIGHT, 32'hFFFF_FFFE, 4);
    send_bad_header(AT_PLANES, 32'd2, 2);
    send_bad_header(AT_BIT_COUNT, 32'd32, 2);
    send_bad_header(AT_COMPRESSION, 32'd3, 4);
    // Empty images at the largest accepted dimensions; later bytes are ignored.
    start_header(MAX_DIM, 0, PIXEL_START, BPP_16);
    add_junk(4);
    send_file(1'b1);
    start_header(0, MAX_DIM, PIXEL_START, BPP_24);
    add_junk(4);
    send_file(1'b1);
    // Pixel offset below the header end, one pixel, trailing padding and junk.
    start_header(1, 1, 0, BPP_24);
    add_pixels(1, 1, BPP_24, 0, 1);
    add_junk(5);
    send_file(1'b1);
    // Offset past the header, 16-bit rows with two pad bytes.
    start_header(3, 2, 60, BPP_16);
    add_pixels(3, 2, BPP_16, 60, 2);
    send_file(1'b1);
    // 24-bit rows counting upward with one pad byte.
    start_header(5, 3, PIXEL_START, BPP_24);
    add_pixels(5, 3, BPP_24, PIXEL_START, 3);
    send_file(1'b1);
    // Tallest image starts at the top row.
    calm <= 1'b1;
    start_header(1, MAX_DIM, PIXEL_START, BPP_16);
    add_pixels(1, MAX_DIM, BPP_16, PIXEL_START, 3);
    send_file(1'b1);
    calm <= 1'b0;
  endtask

  // Mostly well-formed files with random content, some broken ones and noise.
  task automatic random_file();
    int unsigned roll;
    int unsigned what;
    int unsigned w;
    int unsigned h;
    logic [31:0] offset;
    logic [31:0] value;
    logic [15:0] bpp;
    roll   = $urandom_range(0, 99);
    what   = $urandom_range(0, 9);
    calm   <= ($urandom_range(0, 6) == 0);
    bpp    = ($urandom_range(0, 1) != 0) ? BPP_24 : BPP_16;
    w      = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    h      = $urandom_range(1, 4);
    offset = (what < 3) ? $urandom_range(0, 54) :
             (what < 8) ? PIXEL_START : PIXEL_START + $urandom_range(1, 10);
    if (roll >= 95) begin
      // Noise: ignored or quickly rejected bytes.
      file_q.delete();
      add_junk($urandom_range(1, 20));
      send_file($urandom_range(0, 1) != 0);
    end else begin
      start_header(w, h, offset, bpp);
      if (roll < 70) begin
        add_pixels(w, h, bpp, offset, h);
        if ($urandom_range(0, 2) == 0) add_junk($urandom_range(1, 4));
      end else if (roll < 80) begin
        // Cut off anywhere, the next file restarts the parser.
        add_pixels(w, h, bpp, offset, h);
        repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
      end else if (roll < 90) begin
        case ($urandom_range(0, 6))
          0: file_q[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
          1: begin
            value = $urandom;
            if (value == INFO_SIZE) value = 32'd41;
            put_le(AT_INFO_SIZE, value, 4);
          end
          2: put_le(AT_WIDTH, $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF), 4);
          3: put_le(AT_HEIGHT, $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF), 4);
          4: begin
            value = $urandom_range(0, 65535);
            if (value == 32'(ONE_PLANE)) value = 32'd0;
            put_le(AT_PLANES, value, 2);
          end
          5: begin
            value = $urandom_range(0, 65535);
            if (value == 32'(BPP_16) || value == 32'(BPP_24)) value = 32'd32;
            put_le(AT_BIT_COUNT, value, 2);
          end
          default: put_le(AT_COMPRESSION, $urandom_range(1, 32'hFFFF_FFFF), 4);
        endcase
        add_junk($urandom_range(0, 4));
      end else begin
        // Empty image: zero width or zero height.
        if ($urandom_range(0, 1) != 0) put_le(AT_WIDTH, 32'd0, 4);
        else put_le(AT_HEIGHT, 32'd0, 4);
        add_junk($urandom_range(0, 6));
      end
      random_bytes += file_q.size();
      send_file(1'b1);
    end
  endtask

  initial begin
    int unsigned drain;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    while (random_bytes < RANDOM_BYTES) random_file();
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (waiting != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (waiting != 0) $error("%0d expected results never arrived", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### bmp_stream_parser.f
hw/rtl/bsp_pkg.sv
hw/rtl/bmp_stream_parser.sv
hw/rtl/bsp_checker.sv
test/bmp_stream_parser_checker.sv
test/bmp_stream_parser_tb.sv
